// File: rtl/core/md4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package md4_pkg;

    localparam int WORD_W    = 32;
    localparam int LEN_W     = 64;
    localparam int STEP_W    = 6;
    localparam int POS_W     = 4;
    localparam int IDX_W     = 2;
    localparam int REG_IDX_W = 3;
    localparam int BLOCK_WORDS = 16;

    localparam logic [REG_IDX_W-1:0] REG_INIT_A     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INIT_B     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INIT_C     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INIT_D     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INIT_BYTES = 3'd4;

    localparam logic [2:0] SRC_IN    = 3'd0;
    localparam logic [2:0] SRC_DATA  = 3'd1;
    localparam logic [2:0] SRC_PAD   = 3'd2;
    localparam logic [2:0] SRC_ZERO  = 3'd3;
    localparam logic [2:0] SRC_LENLO = 3'd4;
    localparam logic [2:0] SRC_LENHI = 3'd5;
    localparam logic [2:0] SRC_DONE  = 3'd6;

    localparam logic [WORD_W-1:0] ROUND2_K = 32'h5A827999;
    localparam logic [WORD_W-1:0] ROUND3_K = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] IV_A     = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B     = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] IV_C     = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] IV_D     = 32'h10325476;

    localparam logic [STEP_W-1:0] LAST_STEP = 6'd47;
    localparam logic [IDX_W-1:0]  LAST_IDX  = 2'd3;

    typedef struct packed {
        logic              take;
        logic              start;
        logic              push;
        logic [2:0]        src;
        logic              load_v;
        logic              round;
        logic              feed;
        logic [STEP_W-1:0] step;
        logic [IDX_W-1:0]  out_idx;
    } md4_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_13;
    } md4_stat_t;

    // Message word used by a step; the third round visits words in bit-reversed order.
    function automatic logic [POS_W-1:0] md4_widx(input logic [STEP_W-1:0] step);
        logic [POS_W-1:0] j;
        logic [POS_W-1:0] r;
        begin
            j = step[3:0];
            case (step[5:4])
                2'd0: r = j;
                2'd1: r = {j[1:0], j[3:2]};
                2'd2: r = {j[0], j[1], j[2], j[3]};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [WORD_W-1:0] md4_rotl(input logic [WORD_W-1:0] v,
                                                   input logic [STEP_W-1:0] step);
        logic [WORD_W-1:0] r;
        logic [4:0]        sh;
        begin
            case (step[5:4])
                2'd0:
                begin
                    case (step[1:0])
                        2'd0: sh = 5'd3;
                        2'd1: sh = 5'd7;
                        2'd2: sh = 5'd11;
                        default: sh = 5'd19;
                    endcase
                end
                2'd1:
                begin
                    case (step[1:0])
                        2'd0: sh = 5'd3;
                        2'd1: sh = 5'd5;
                        2'd2: sh = 5'd9;
                        default: sh = 5'd13;
                    endcase
                end
                default:
                begin
                    case (step[1:0])
                        2'd0: sh = 5'd3;
                        2'd1: sh = 5'd9;
                        2'd2: sh = 5'd11;
                        default: sh = 5'd15;
                    endcase
                end
            endcase
            case (sh)
                5'd3:  r = {v[28:0], v[31:29]};
                5'd5:  r = {v[26:0], v[31:27]};
                5'd7:  r = {v[24:0], v[31:25]};
                5'd9:  r = {v[22:0], v[31:23]};
                5'd11: r = {v[20:0], v[31:21]};
                5'd13: r = {v[18:0], v[31:19]};
                5'd15: r = {v[16:0], v[31:17]};
                5'd19: r = {v[12:0], v[31:13]};
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/md4_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module md4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/md4_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module md4_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_last,
    input  wire logic [2:0]        in_cnt,
    input  wire logic              out_ready,
    input  wire md4_pkg::md4_stat_t stat,
    output logic                   in_ready,
    output logic                   out_valid,
    output md4_pkg::md4_cmd_t      cmd
);

    import md4_pkg::*;

    localparam logic [2:0] S_IN    = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FEED  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              idle_reg, idle_next;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        idle_next   = idle_reg;
        cmd         = '0;
        cmd.step    = step_reg;
        cmd.out_idx = idx_reg;
        cmd.src     = phase_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            S_IN:
            begin
                in_ready = 1'b1;
                cmd.src  = SRC_IN;
                // An empty word that does not close the message is dropped.
                if (in_valid && (in_last || in_cnt != 3'd0))
                begin
                    cmd.take  = 1'b1;
                    cmd.start = idle_reg;
                    idle_next = 1'b0;
                    if (!in_last)
                    begin
                        cmd.push = 1'b1;
                        if (stat.pos_last)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                    else
                    begin
                        phase_next = in_cnt[2] ? SRC_DATA : SRC_PAD;
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                case (phase_reg)
                    SRC_DATA:           phase_next = SRC_PAD;
                    SRC_PAD, SRC_ZERO:  phase_next = stat.pos_13 ? SRC_LENLO : SRC_ZERO;
                    SRC_LENLO:          phase_next = SRC_LENHI;
                    SRC_LENHI:          phase_next = SRC_DONE;
                    default:            phase_next = phase_reg;
                endcase
                if (stat.pos_last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_v = 1'b1;
                step_next  = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_FEED;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            S_FEED:
            begin
                cmd.feed = 1'b1;
                if (phase_reg == SRC_DONE)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else if (phase_reg == SRC_IN)
                begin
                    state_next = S_IN;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        idle_next  = 1'b1;
                        phase_next = SRC_IN;
                        state_next = S_IN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            phase_reg <= SRC_IN;
            step_reg  <= '0;
            idx_reg   <= '0;
            idle_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            idle_reg  <= idle_next;
        end
    end

`ifndef SYNTHESIS
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("Input and output offered in the same cycle.");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && step_reg == LAST_STEP) |=> state_reg == S_FEED)
        else $error("Compression did not end after the last step.");

    a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |=> (state_reg == S_ROUND && step_reg == '0))
        else $error("Compression did not start at step zero.");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && idx_reg == LAST_IDX) |=> (idle_reg && state_reg == S_IN))
        else $error("Engine not idle after the final digest word.");
`endif

endmodule

`default_nettype wire

// File: rtl/core/md4_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module md4_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [md4_pkg::REG_IDX_W-1:0]   cfg_addr,
    input  wire logic [md4_pkg::LEN_W-1:0]       cfg_wdata,
    input  wire logic [md4_pkg::WORD_W-1:0]      in_data,
    input  wire logic [2:0]                      in_cnt,
    input  wire logic                            in_last,
    input  wire md4_pkg::md4_cmd_t               cmd,
    output md4_pkg::md4_stat_t                   stat,
    output logic      [md4_pkg::WORD_W-1:0]      digest
);

    import md4_pkg::*;

    logic [WORD_W-1:0] init_a_reg, init_b_reg, init_c_reg, init_d_reg;
    logic [LEN_W-1:0]  init_bytes_reg;
    logic [WORD_W-1:0] chain_a_reg, chain_b_reg, chain_c_reg, chain_d_reg;
    logic [WORD_W-1:0] va_reg, vb_reg, vc_reg, vd_reg;
    logic [LEN_W-1:0]  msg_reg;
    logic [WORD_W-1:0] hold_data_reg;
    logic [1:0]        hold_cnt_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic [2:0]        cnt_eff;
    logic [LEN_W-1:0]  msg_base;
    logic [WORD_W-1:0] pad_word;
    logic [WORD_W-1:0] wr_word;
    logic [STEP_W-1:0] rd_step;
    logic [POS_W-1:0]  raddr;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] k_val;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] new_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_a_reg     <= IV_A;
            init_b_reg     <= IV_B;
            init_c_reg     <= IV_C;
            init_d_reg     <= IV_D;
            init_bytes_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_INIT_A:     init_a_reg     <= cfg_wdata[WORD_W-1:0];
                REG_INIT_B:     init_b_reg     <= cfg_wdata[WORD_W-1:0];
                REG_INIT_C:     init_c_reg     <= cfg_wdata[WORD_W-1:0];
                REG_INIT_D:     init_d_reg     <= cfg_wdata[WORD_W-1:0];
                REG_INIT_BYTES: init_bytes_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign cnt_eff  = (!in_last || in_cnt[2]) ? 3'd4 : in_cnt;
    assign msg_base = cmd.start ? init_bytes_reg : msg_reg;

    always_comb
    begin
        case (hold_cnt_reg)
            2'd0:    pad_word = 32'h0000_0080;
            2'd1:    pad_word = {16'h0000, 8'h80, hold_data_reg[7:0]};
            2'd2:    pad_word = {8'h00, 8'h80, hold_data_reg[15:0]};
            default: pad_word = {8'h80, hold_data_reg[23:0]};
        endcase
    end

    always_comb
    begin
        case (cmd.src)
            SRC_IN:    wr_word = in_data;
            SRC_DATA:  wr_word = hold_data_reg;
            SRC_PAD:   wr_word = pad_word;
            SRC_LENLO: wr_word = {msg_reg[28:0], 3'b000};
            SRC_LENHI: wr_word = msg_reg[60:29];
            default:   wr_word = '0;
        endcase
    end

    assign pos_next      = cmd.push ? pos_reg + 4'd1 : pos_reg;
    assign stat.pos_last = (pos_reg == 4'd15);
    assign stat.pos_13   = (pos_reg == 4'd13);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // The read for the next step is issued in the cycle before that step uses it.
    assign rd_step = cmd.load_v ? '0 : cmd.step + 6'd1;
    assign raddr   = md4_widx(rd_step);

    md4_ram #(
        .WIDTH(WORD_W),
        .DEPTH(BLOCK_WORDS)
    ) u_block (
        .clk  (clk),
        .we   (cmd.push),
        .waddr(pos_reg),
        .wdata(wr_word),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        case (cmd.step[5:4])
            2'd0:
            begin
                f_val = (vb_reg & vc_reg) | (~vb_reg & vd_reg);
                k_val = '0;
            end
            2'd1:
            begin
                f_val = (vb_reg & vc_reg) | (vb_reg & vd_reg) | (vc_reg & vd_reg);
                k_val = ROUND2_K;
            end
            default:
            begin
                f_val = vb_reg ^ vc_reg ^ vd_reg;
                k_val = ROUND3_K;
            end
        endcase
    end

    assign sum   = va_reg + f_val + rdata + k_val;
    assign new_b = md4_rotl(sum, cmd.step);

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            msg_reg       <= msg_base + {61'd0, cnt_eff};
            hold_data_reg <= in_data;
            hold_cnt_reg  <= in_cnt[2] ? 2'd0 : in_cnt[1:0];
        end
        if (cmd.start)
        begin
            chain_a_reg <= init_a_reg;
            chain_b_reg <= init_b_reg;
            chain_c_reg <= init_c_reg;
            chain_d_reg <= init_d_reg;
        end
        else if (cmd.feed)
        begin
            chain_a_reg <= chain_a_reg + va_reg;
            chain_b_reg <= chain_b_reg + vb_reg;
            chain_c_reg <= chain_c_reg + vc_reg;
            chain_d_reg <= chain_d_reg + vd_reg;
        end
        if (cmd.load_v)
        begin
            va_reg <= chain_a_reg;
            vb_reg <= chain_b_reg;
            vc_reg <= chain_c_reg;
            vd_reg <= chain_d_reg;
        end
        else if (cmd.round)
        begin
            va_reg <= vd_reg;
            vb_reg <= new_b;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_comb
    begin
        case (cmd.out_idx)
            2'd0:    digest = chain_a_reg;
            2'd1:    digest = chain_b_reg;
            2'd2:    digest = chain_c_reg;
            default: digest = chain_d_reg;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/md4_hash_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// MD4 hash engine. Message words enter on the slave stream one at a time; a word that does not
// close a block is taken without a stall, and the sixteenth word of a block starts a compression
// (one MD4 step per cycle, paced by the block memory's single read port, plus a load and a
// feed-forward step), during which no message word is taken. The word marked last is followed
// by padding, one word per cycle outside compressions, one or two further compressions, and then
// the four digest words A, B, C, D on the master stream; no new message word is taken until the
// fourth digest word has been accepted. The starting chain words and byte count are loaded from
// the configuration registers when a message begins.
module md4_hash_engine_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // data_word [31:0], byte_count [34:32]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // digest_word [31:0]
    output logic      [1:0]  m_axis_tuser,   // word_index [1:0]
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata
);

    import md4_pkg::*;

    md4_cmd_t  cmd;
    md4_stat_t stat;

    md4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_cnt   (s_axis_tdata[34:32]),
        .out_ready(m_axis_tready),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .cmd      (cmd)
    );

    md4_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_data  (s_axis_tdata[31:0]),
        .in_cnt   (s_axis_tdata[34:32]),
        .in_last  (s_axis_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .digest   (m_axis_tdata)
    );

    assign m_axis_tuser = cmd.out_idx;
    assign m_axis_tlast = (cmd.out_idx == LAST_IDX);

endmodule

`default_nettype wire
